// ===== rtl/glce_pkg.sv =====
// Shared types and constants for the grid Laplacian and curl engine.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package glce_pkg;

	localparam int PT_W      = 6;
	localparam int PT_EXT_W  = 9;
	localparam int VAL_W     = 32;
	localparam int COEF_W    = 32;
	localparam int HALF_W    = 16;
	localparam int NUM_COMP  = 4;
	localparam int NUM_AXIS  = 3;
	localparam int NUM_OUT   = 10;
	localparam int WORD_W    = NUM_COMP * VAL_W;
	localparam int CFG_IDX_W = 3;

	localparam int NUM_SLOT  = 7;
	localparam int SLOT_W    = 3;
	localparam int NUM_STEP  = 14;
	localparam int STEP_W    = 4;
	localparam int PIPE_LAT  = 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SQ_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQ_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SQ_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TW_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TW_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TW_Z = 3'd5;

	localparam logic [COEF_W-1:0] SQ_RST = 32'h0400_0000;
	localparam logic [COEF_W-1:0] TW_RST = 32'h0010_0000;

	typedef struct packed {
		logic              wr;
		logic              cap;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_slot;
		logic              clr;
		logic              mul;
		logic [STEP_W-1:0] step;
		logic              fin;
	} glce_ctl_t;

endpackage

// ===== rtl/glce_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module glce_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/glce_ctrl.sv =====
// Controller: strobes grid writes; sequences grid reads, multiply steps
// and result output. Depends on glce_pkg.
`timescale 1ns / 1ps
module glce_ctrl import glce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      cmd,
	output logic      busy,
	output glce_ctl_t ctl
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam logic [STEP_W-1:0] RD_LAST    = STEP_W'(NUM_SLOT);
	localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(NUM_STEP - 1);
	localparam logic [STEP_W-1:0] DRAIN_LAST = STEP_W'(PIPE_LAT - 1);

	logic [2:0]        state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              acc;

	assign acc  = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ctl         = '0;
		ctl.wr      = acc && (cmd == CMD_WRITE);
		ctl.cap     = acc && (cmd == CMD_EVAL);
		ctl.rd_en   = (state_q == ST_READ) && (cnt_q < RD_LAST);
		ctl.rd_slot = cnt_q[SLOT_W-1:0];
		ctl.clr     = (state_q == ST_READ) && (cnt_q == RD_LAST);
		ctl.mul     = (state_q == ST_MUL);
		ctl.step    = cnt_q;
		ctl.fin     = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (ctl.cap) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cnt_q == RD_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cnt_q == DRAIN_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/glce_dp.sv =====
// Datapath: grid memory, neighbour fetch, three axis multiplier lanes,
// accumulators, rounding and saturation. Depends on glce_pkg and glce_ram.
`timescale 1ns / 1ps
module glce_dp import glce_pkg::*; #(
	parameter int GRID_SIDE  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  glce_ctl_t                        ctl,
	input  logic [PT_W-1:0]                  px,
	input  logic [PT_W-1:0]                  py,
	input  logic [PT_W-1:0]                  pz,
	input  logic signed [VAL_W-1:0]          pot_t,
	input  logic signed [VAL_W-1:0]          pot_x,
	input  logic signed [VAL_W-1:0]          pot_y,
	input  logic signed [VAL_W-1:0]          pot_z,
	input  logic                             cfg_we,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [COEF_W-1:0]                cfg_data,
	output logic                             done,
	output logic [NUM_OUT-1:0][VAL_W-1:0]    res
);

	localparam int IDX_W  = $clog2(GRID_SIDE);
	localparam int ADDR_W = NUM_AXIS * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(GRID_SIDE - 1);

	localparam int DIFF_W = VAL_W + 3;
	localparam int MUL_W  = DIFF_W + HALF_W + 1;
	localparam int PROD_W = MUL_W + HALF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int RND_W  = ACC_W - HALF_W;
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (HALF_W - 1));
	localparam logic signed [RND_W-1:0] SAT_MAX =
		RND_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_MIN = ~SAT_MAX;

	localparam logic [SLOT_W-1:0] SLOT_XP = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_XM = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_YP = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_YM = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_ZP = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_ZM = 3'd6;

	localparam logic [2:0] PRD_E     = 3'd4;
	localparam logic [2:0] PRD_B_FWD = 3'd5;
	localparam logic [2:0] PRD_B_BWD = 3'd6;
	localparam logic [1:0] COMP_T    = 2'd0;
	localparam int OUT_E = 4;
	localparam int OUT_B = 7;
	localparam int AX_NEXT [NUM_AXIS] = '{1, 2, 0};
	localparam int AX_PREV [NUM_AXIS] = '{2, 0, 1};

	function automatic logic [IDX_W-1:0] clamp_pt(input logic [PT_W-1:0] v);
		logic [PT_EXT_W-1:0] e;
		e = PT_EXT_W'(v);
		if (e > PT_EXT_W'(GRID_SIDE - 1)) begin
			return LAST;
		end
		return e[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] inc_pt(input logic [IDX_W-1:0] v);
		return (v == LAST) ? v : v + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] dec_pt(input logic [IDX_W-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	function automatic logic signed [DIFF_W-1:0] comp_of(input logic [WORD_W-1:0] w,
		input logic [1:0] c);
		logic signed [VAL_W-1:0] v;
		v = w[(NUM_COMP - 1 - int'(c)) * VAL_W +: VAL_W];
		return DIFF_W'(v);
	endfunction

	function automatic logic [3:0] tgt(input int k, input logic [2:0] p);
		case (p)
			PRD_E:     return 4'(OUT_E + k);
			PRD_B_FWD: return 4'(OUT_B + AX_PREV[k]);
			PRD_B_BWD: return 4'(OUT_B + AX_NEXT[k]);
			default:   return 4'(p);
		endcase
	endfunction

	// coefficient registers
	logic [COEF_W-1:0] sq_q [NUM_AXIS];
	logic [COEF_W-1:0] tw_q [NUM_AXIS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXIS; k++) begin
				sq_q[k] <= SQ_RST;
				tw_q[k] <= TW_RST;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SQ_X: sq_q[0] <= cfg_data;
				CFG_SQ_Y: sq_q[1] <= cfg_data;
				CFG_SQ_Z: sq_q[2] <= cfg_data;
				CFG_TW_X: tw_q[0] <= cfg_data;
				CFG_TW_Y: tw_q[1] <= cfg_data;
				CFG_TW_Z: tw_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// grid memory and neighbour fetch
	logic [IDX_W-1:0]  cp_q [NUM_AXIS];
	logic [IDX_W-1:0]  ra [NUM_AXIS];
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] ram_addr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic              rd_vld_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [WORD_W-1:0] slot_q [NUM_SLOT];

	assign wr_addr   = {clamp_pt(px), clamp_pt(py), clamp_pt(pz)};
	assign ram_wdata = {pot_t, pot_x, pot_y, pot_z};
	assign ram_addr  = ctl.rd_en ? {ra[0], ra[1], ra[2]} : wr_addr;

	always_comb begin
		for (int k = 0; k < NUM_AXIS; k++) begin
			ra[k] = cp_q[k];
		end
		case (ctl.rd_slot)
			SLOT_XP: ra[0] = inc_pt(cp_q[0]);
			SLOT_XM: ra[0] = dec_pt(cp_q[0]);
			SLOT_YP: ra[1] = inc_pt(cp_q[1]);
			SLOT_YM: ra[1] = dec_pt(cp_q[1]);
			SLOT_ZP: ra[2] = inc_pt(cp_q[2]);
			SLOT_ZM: ra[2] = dec_pt(cp_q[2]);
			default: ;
		endcase
	end

	glce_ram #(
		.W     (WORD_W),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ctl.wr),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cp_q[0] <= clamp_pt(px);
			cp_q[1] <= clamp_pt(py);
			cp_q[2] <= clamp_pt(pz);
		end
		rd_slot_q <= ctl.rd_slot;
		if (rd_vld_q) begin
			slot_q[rd_slot_q] <= ram_rdata;
		end
	end

	// operand select per axis lane
	logic [2:0]               p_mul;
	logic [1:0]               cs [NUM_AXIS];
	logic                     lap_m [NUM_AXIS];
	logic                     neg_m [NUM_AXIS];
	logic signed [DIFF_W-1:0] pv [NUM_AXIS];
	logic signed [DIFF_W-1:0] mv [NUM_AXIS];
	logic signed [DIFF_W-1:0] cv [NUM_AXIS];
	logic signed [DIFF_W-1:0] dsel [NUM_AXIS];
	logic [COEF_W-1:0]        coef [NUM_AXIS];
	logic [HALF_W-1:0]        msel [NUM_AXIS];

	assign p_mul = ctl.step[STEP_W-1:1];

	always_comb begin
		for (int k = 0; k < NUM_AXIS; k++) begin
			lap_m[k] = 1'b0;
			neg_m[k] = 1'b0;
			case (p_mul)
				PRD_E: begin
					cs[k]    = COMP_T;
					neg_m[k] = 1'b1;
				end
				PRD_B_FWD: begin
					cs[k] = 2'(AX_NEXT[k] + 1);
				end
				PRD_B_BWD: begin
					cs[k]    = 2'(AX_PREV[k] + 1);
					neg_m[k] = 1'b1;
				end
				default: begin
					cs[k]    = p_mul[1:0];
					lap_m[k] = 1'b1;
				end
			endcase
			pv[k] = comp_of(slot_q[1 + 2 * k], cs[k]);
			mv[k] = comp_of(slot_q[2 + 2 * k], cs[k]);
			cv[k] = comp_of(slot_q[0], cs[k]);
			if (lap_m[k]) begin
				dsel[k] = pv[k] + mv[k] - (cv[k] <<< 1);
			end else if (neg_m[k]) begin
				dsel[k] = mv[k] - pv[k];
			end else begin
				dsel[k] = pv[k] - mv[k];
			end
			coef[k] = (p_mul < PRD_E) ? sq_q[k] : tw_q[k];
			msel[k] = ctl.step[0] ? coef[k][COEF_W-1:HALF_W] : coef[k][HALF_W-1:0];
		end
	end

	// multiply pipeline
	logic signed [DIFF_W-1:0] d_s1 [NUM_AXIS];
	logic [HALF_W-1:0]        m_s1 [NUM_AXIS];
	logic                     hi_s1;
	logic [2:0]               p_s1;
	logic                     vld_s1;
	logic signed [MUL_W-1:0]  mul_w [NUM_AXIS];
	logic signed [PROD_W-1:0] prod_s2 [NUM_AXIS];
	logic [2:0]               p_s2;
	logic                     vld_s2;

	always_comb begin
		for (int k = 0; k < NUM_AXIS; k++) begin
			mul_w[k] = d_s1[k] * $signed({1'b0, m_s1[k]});
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_AXIS; k++) begin
			d_s1[k] <= dsel[k];
			m_s1[k] <= msel[k];
			prod_s2[k] <= hi_s1 ? {mul_w[k], {HALF_W{1'b0}}}
			                    : {{HALF_W{mul_w[k][MUL_W-1]}}, mul_w[k]};
		end
		hi_s1 <= ctl.step[0];
		p_s1  <= p_mul;
		p_s2  <= p_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			done     <= 1'b0;
		end else begin
			rd_vld_q <= ctl.rd_en;
			vld_s1   <= ctl.mul;
			vld_s2   <= vld_s1;
			done     <= ctl.fin;
		end
	end

	// accumulate, round half up, saturate
	logic signed [ACC_W-1:0] acc_q [NUM_OUT];
	logic signed [ACC_W-1:0] add_w [NUM_OUT];
	logic signed [ACC_W-1:0] rsum [NUM_OUT];
	logic signed [RND_W-1:0] rv [NUM_OUT];
	logic signed [RND_W-1:0] sv [NUM_OUT];

	always_comb begin
		for (int o = 0; o < NUM_OUT; o++) begin
			add_w[o] = '0;
			for (int k = 0; k < NUM_AXIS; k++) begin
				if (tgt(k, p_s2) == 4'(o)) begin
					add_w[o] = add_w[o] + ACC_W'(prod_s2[k]);
				end
			end
			rsum[o] = acc_q[o] + RND_HALF;
			rv[o]   = rsum[o][ACC_W-1:HALF_W];
			if (rv[o] > SAT_MAX) begin
				sv[o] = SAT_MAX;
			end else if (rv[o] < SAT_MIN) begin
				sv[o] = SAT_MIN;
			end else begin
				sv[o] = rv[o];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int o = 0; o < NUM_OUT; o++) begin
			if (ctl.clr) begin
				acc_q[o] <= '0;
			end else if (vld_s2) begin
				acc_q[o] <= acc_q[o] + add_w[o];
			end
			if (ctl.fin) begin
				res[o] <= sv[o][VAL_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/grid_laplacian_and_curl_engine.sv =====
// Evaluate: done is high in the cycle in which busy falls, and evaluations
// cannot overlap, since a new start is accepted only while busy is low.
// The busy span covers seven reads from the single-port grid RAM plus 14
// steps of three 35x17 axis multipliers and a two-stage product pipeline.
// Write: no result, busy stays low, next transaction in the following cycle.
// Reset clears control and restores coefficients; grid contents stay undefined.
`timescale 1ns / 1ps
module grid_laplacian_and_curl_engine import glce_pkg::*; #(
	parameter int GRID_SIDE  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    cmd,
	input  logic [PT_W-1:0]         px,
	input  logic [PT_W-1:0]         py,
	input  logic [PT_W-1:0]         pz,
	input  logic signed [VAL_W-1:0] pot_t,
	input  logic signed [VAL_W-1:0] pot_x,
	input  logic signed [VAL_W-1:0] pot_y,
	input  logic signed [VAL_W-1:0] pot_z,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [COEF_W-1:0]       cfg_data,
	output logic                    done,
	output logic signed [VAL_W-1:0] lap_t,
	output logic signed [VAL_W-1:0] lap_x,
	output logic signed [VAL_W-1:0] lap_y,
	output logic signed [VAL_W-1:0] lap_z,
	output logic signed [VAL_W-1:0] efield_x,
	output logic signed [VAL_W-1:0] efield_y,
	output logic signed [VAL_W-1:0] efield_z,
	output logic signed [VAL_W-1:0] bfield_x,
	output logic signed [VAL_W-1:0] bfield_y,
	output logic signed [VAL_W-1:0] bfield_z
);

	glce_ctl_t                     ctl;
	logic [NUM_OUT-1:0][VAL_W-1:0] res;

	glce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.ctl    (ctl)
	);

	glce_dp #(
		.GRID_SIDE  (GRID_SIDE),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.pot_t     (pot_t),
		.pot_x     (pot_x),
		.pot_y     (pot_y),
		.pot_z     (pot_z),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.res       (res)
	);

	assign lap_t    = res[0];
	assign lap_x    = res[1];
	assign lap_y    = res[2];
	assign lap_z    = res[3];
	assign efield_x = res[4];
	assign efield_y = res[5];
	assign efield_z = res[6];
	assign bfield_x = res[7];
	assign bfield_y = res[8];
	assign bfield_z = res[9];

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_EVAL) |=> busy)
		else $error("evaluate transaction did not raise busy");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_WRITE) |=> !busy)
		else $error("write transaction held the block busy");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("evaluation ended without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(ctl.fin)))
		else $error("result strobe outside end of evaluation");

endmodule
